// ===== src/feature_occupancy_grid_defines.svh =====
// assertion macros used by the checker file
`ifndef FEATURE_OCCUPANCY_GRID_DEFINES_SVH
`define FEATURE_OCCUPANCY_GRID_DEFINES_SVH

// clocked check, switched off while reset is held
`define FOG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked check that also runs through reset
`define FOG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/fog_pkg.sv =====
package fog_pkg;

  localparam int COORD_W          = 12;
  localparam int DEF_GRID_COLUMNS = 16;
  localparam int DEF_GRID_ROWS    = 16;
  localparam int QUEUE_DEPTH      = 2;

  // operation codes
  localparam logic [1:0] OP_MARK  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // register indexes
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic [COORD_W-1:0] RST_IMAGE_WIDTH  = 12'd16;
  localparam logic [COORD_W-1:0] RST_IMAGE_HEIGHT = 12'd16;

  // classified item: operation plus cell column and row
  typedef struct packed {
    logic [1:0]         op;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } fog_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fog_qstat_t;

endpackage

// ===== src/fog_div.sv =====
module fog_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fog_pkg::COORD_W-1:0] dividend,
  input  logic [fog_pkg::COORD_W-1:0] divisor,
  output logic                        done,
  output logic [fog_pkg::COORD_W-1:0] quotient
);
  import fog_pkg::*;

  localparam int CNT_W = $clog2(COORD_W + 1);

  logic [COORD_W-1:0] rem_r, rem_nxt;
  logic [COORD_W-1:0] quo_r, quo_nxt;
  logic [COORD_W-1:0] div_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               run_r;
  logic               done_r;
  logic [COORD_W:0]   shifted;
  logic [COORD_W:0]   diff;
  logic               ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem_r, quo_r[COORD_W-1]};
    diff    = shifted - {1'b0, div_r};
    ge      = shifted >= {1'b0, div_r};
    rem_nxt = ge ? diff[COORD_W-1:0] : shifted[COORD_W-1:0];
    quo_nxt = {quo_r[COORD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(COORD_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== src/fog_queue.sv =====
module fog_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fog_pkg::fog_item_t push_item,
  input  logic               pop,
  output fog_pkg::fog_item_t head,
  output fog_pkg::fog_qstat_t stat
);
  import fog_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  fog_item_t        slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat.full  = cnt_r == CNT_W'(QUEUE_DEPTH);
  assign stat.empty = cnt_r == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

// ===== src/fog_front.sv =====
module fog_front #(
  parameter int GRID_COLUMNS = fog_pkg::DEF_GRID_COLUMNS,
  parameter int GRID_ROWS    = fog_pkg::DEF_GRID_ROWS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_opcode,
  input  logic [fog_pkg::COORD_W-1:0] in_x_coord,
  input  logic [fog_pkg::COORD_W-1:0] in_y_coord,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [fog_pkg::COORD_W-1:0] cfg_data,
  input  fog_pkg::fog_qstat_t         q_stat,
  output logic                        q_push,
  output fog_pkg::fog_item_t          q_item
);
  import fog_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_SIZE = 2'd1;
  localparam logic [1:0] F_DIV  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  localparam logic [COORD_W-1:0] GC_W = COORD_W'(GRID_COLUMNS);
  localparam logic [COORD_W-1:0] GR_W = COORD_W'(GRID_ROWS);

  logic [1:0]         state_r, state_nxt;
  logic               dirty_r, dirty_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [COORD_W-1:0] iw_r, ih_r;
  logic [COORD_W-1:0] cw_r, ch_r;
  logic [COORD_W-1:0] col_r, row_r;
  logic               div_go;
  logic [COORD_W-1:0] dx_dividend, dy_dividend, dx_divisor, dy_divisor;
  logic [COORD_W-1:0] dx_q, dy_q;
  logic               dx_done, dy_done, div_done;

  function automatic logic [COORD_W-1:0] clamp_size(input logic [COORD_W-1:0] q);
    return (q == '0) ? COORD_W'(1) : q;
  endfunction

  assign busy     = (state_r != F_IDLE) || dirty_r;
  assign div_done = dx_done && dy_done;

  // pending size update uses the dividers on the image extent and grid count
  assign dx_dividend = dirty_r ? iw_r : in_x_coord;
  assign dy_dividend = dirty_r ? ih_r : in_y_coord;
  assign dx_divisor  = dirty_r ? GC_W : cw_r;
  assign dy_divisor  = dirty_r ? GR_W : ch_r;

  fog_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (dx_dividend),
    .divisor  (dx_divisor),
    .done     (dx_done),
    .quotient (dx_q)
  );

  fog_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (dy_dividend),
    .divisor  (dy_divisor),
    .done     (dy_done),
    .quotient (dy_q)
  );

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    div_go    = 1'b0;
    q_push    = 1'b0;
    dirty_nxt = dirty_r;
    unique case (state_r)
      F_IDLE: begin
        if (dirty_r) begin
          div_go    = 1'b1;
          dirty_nxt = 1'b0;
          state_nxt = F_SIZE;
        end else if (start) begin
          op_nxt = in_opcode;
          unique case (in_opcode) inside
            OP_MARK, OP_QUERY: begin
              div_go    = 1'b1;
              state_nxt = F_DIV;
            end
            OP_CLEAR: state_nxt = F_PUSH;
            default: state_nxt = F_IDLE;
          endcase
        end
      end
      F_SIZE: if (div_done) state_nxt = F_IDLE;
      F_DIV:  if (div_done) state_nxt = F_PUSH;
      F_PUSH: begin
        if (!q_stat.full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
    if (cfg_we) dirty_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      dirty_r <= 1'b1;
      iw_r    <= RST_IMAGE_WIDTH;
      ih_r    <= RST_IMAGE_HEIGHT;
    end else begin
      state_r <= state_nxt;
      dirty_r <= dirty_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IDX_WIDTH:  iw_r <= cfg_data;
          CFG_IDX_HEIGHT: ih_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    if (state_r == F_SIZE && div_done) begin
      cw_r <= clamp_size(dx_q);
      ch_r <= clamp_size(dy_q);
    end
    if (state_r == F_DIV && div_done) begin
      col_r <= dx_q;
      row_r <= dy_q;
    end
  end

  assign q_item = '{op: op_r, col: col_r, row: row_r};

endmodule

// ===== src/fog_back.sv =====
module fog_back #(
  parameter int GRID_COLUMNS = fog_pkg::DEF_GRID_COLUMNS,
  parameter int GRID_ROWS    = fog_pkg::DEF_GRID_ROWS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fog_pkg::fog_qstat_t q_stat,
  input  fog_pkg::fog_item_t  head,
  output logic                pop,
  output logic                out_valid,
  output logic                out_is_new
);
  import fog_pkg::*;

  localparam int CIDX_W = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
  localparam int RIDX_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MRD  = 3'd1;
  localparam logic [2:0] B_MWR  = 3'd2;
  localparam logic [2:0] B_QRD  = 3'd3;
  localparam logic [2:0] B_QCHK = 3'd4;

  localparam logic [COORD_W:0]   GC_X = (COORD_W+1)'(GRID_COLUMNS);
  localparam logic [COORD_W:0]   GR_X = (COORD_W+1)'(GRID_ROWS);
  localparam logic [COORD_W-1:0] GC_W = COORD_W'(GRID_COLUMNS);
  localparam logic [COORD_W-1:0] GR_W = COORD_W'(GRID_ROWS);

  logic [2:0]           state_r, state_nxt;
  logic [COORD_W-1:0]   cur_r, cur_nxt;
  logic [COORD_W-1:0]   row_r, row_nxt;
  logic [COORD_W:0]     c1_r, c1_nxt;
  logic [GRID_ROWS-1:0] mask_r, mask_nxt;
  logic                 acc_r, acc_nxt;
  logic                 out_valid_r, out_is_new_r;
  logic [GRID_COLUMNS-1:0] vld_r;
  logic [GRID_ROWS-1:0] mem_r [GRID_COLUMNS];
  logic [GRID_ROWS-1:0] rd_data_r;
  logic                 rd_vld_r;

  logic [COORD_W-1:0]   c0_h, r0_h;
  logic [COORD_W:0]     col_p2, row_p2, c1_h, r1_h;
  logic [GRID_ROWS-1:0] mask_h;
  logic                 in_grid;
  logic [GRID_ROWS-1:0] eff;
  logic [GRID_ROWS-1:0] mark_word;
  logic                 win_ok;
  logic [CIDX_W-1:0]    cur_idx;
  logic                 mem_we, vld_set, vld_clr, out_go;

  // window bounds of the head item, clipped at the grid edges
  always_comb begin
    c0_h    = (head.col == '0) ? '0 : head.col - 1'b1;
    r0_h    = (head.row == '0) ? '0 : head.row - 1'b1;
    col_p2  = {1'b0, head.col} + (COORD_W+1)'(2);
    row_p2  = {1'b0, head.row} + (COORD_W+1)'(2);
    c1_h    = (col_p2 < GC_X) ? col_p2 : GC_X;
    r1_h    = (row_p2 < GR_X) ? row_p2 : GR_X;
    in_grid = (head.col < GC_W) && (head.row < GR_W);
    for (int r = 0; r < GRID_ROWS; r++) begin
      mask_h[r] = ({1'b0, COORD_W'(r)} >= {1'b0, r0_h}) &&
                  ((COORD_W+1)'(r) < r1_h);
    end
  end

  // a column never written since the last clear reads as all free
  assign cur_idx   = cur_r[CIDX_W-1:0];
  assign eff       = rd_vld_r ? rd_data_r : '1;
  assign win_ok    = (eff & mask_r) == mask_r;
  assign mark_word = eff & ~(GRID_ROWS'(1) << row_r[RIDX_W-1:0]);

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    row_nxt   = row_r;
    c1_nxt    = c1_r;
    mask_nxt  = mask_r;
    acc_nxt   = acc_r;
    pop       = 1'b0;
    mem_we    = 1'b0;
    vld_set   = 1'b0;
    vld_clr   = 1'b0;
    out_go    = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          pop      = 1'b1;
          row_nxt  = head.row;
          c1_nxt   = c1_h;
          mask_nxt = mask_h;
          acc_nxt  = 1'b1;
          unique case (head.op) inside
            OP_MARK: begin
              cur_nxt = head.col;
              if (in_grid) state_nxt = B_MRD;
            end
            OP_QUERY: begin
              cur_nxt   = c0_h;
              state_nxt = B_QRD;
            end
            OP_CLEAR: vld_clr = 1'b1;
            default: state_nxt = B_IDLE;
          endcase
        end
      end
      B_MRD: state_nxt = B_MWR;
      B_MWR: begin
        mem_we    = 1'b1;
        vld_set   = 1'b1;
        state_nxt = B_IDLE;
      end
      B_QRD: begin
        if ({1'b0, cur_r} >= c1_r) begin
          out_go    = 1'b1;
          state_nxt = B_IDLE;
        end else begin
          state_nxt = B_QCHK;
        end
      end
      B_QCHK: begin
        acc_nxt   = acc_r & win_ok;
        cur_nxt   = cur_r + 1'b1;
        state_nxt = B_QRD;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_go;
      if (vld_clr) vld_r <= '0;
      else if (vld_set) vld_r[cur_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    row_r  <= row_nxt;
    c1_r   <= c1_nxt;
    mask_r <= mask_nxt;
    acc_r  <= acc_nxt;
    if (out_go) out_is_new_r <= acc_r;
  end

  // column-wide map memory, registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[cur_idx];
    rd_vld_r  <= vld_r[cur_idx];
    if (mem_we) mem_r[cur_idx] <= mark_word;
  end

  assign out_valid  = out_valid_r;
  assign out_is_new = out_is_new_r;

endmodule

// ===== src/feature_occupancy_grid.sv =====
// mark or query: start is taken when busy is low; busy then stays high while
//   the two 12-step shift-subtract dividers map the point to a cell and it is queued
// query result: out_valid pulses once after the transfer (3x3 window, read and check
//   states per map column); mark and clear give no result; clear holds busy until queued
// reset and every register write recompute cell sizes on the same dividers, holding busy
// synchronous active-low reset; map reads as all free right away, no clearing pass
module feature_occupancy_grid #(
  parameter int GRID_COLUMNS = fog_pkg::DEF_GRID_COLUMNS,
  parameter int GRID_ROWS    = fog_pkg::DEF_GRID_ROWS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_opcode,
  input  logic [fog_pkg::COORD_W-1:0] in_x_coord,
  input  logic [fog_pkg::COORD_W-1:0] in_y_coord,
  // result strobe, one cycle per query
  output logic                        out_valid,
  output logic                        out_is_new,
  // register writes: image width and image height
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [fog_pkg::COORD_W-1:0] cfg_data
);
  import fog_pkg::*;

  // front to queue and queue to back
  fog_item_t  q_item;
  fog_item_t  q_head;
  fog_qstat_t q_stat;
  logic       q_push;
  logic       q_pop;

  // front: takes commands, holds the image size registers and cell sizes,
  // divides the point down to a cell column and row
  fog_front #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_opcode  (in_opcode),
    .in_x_coord (in_x_coord),
    .in_y_coord (in_y_coord),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_item     (q_item)
  );

  // short queue so the front can start the next divide while the back
  // is still scanning the window of the previous point
  fog_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // back: owns the occupancy map (one word per grid column plus a valid
  // bit per column), does read-modify-write for marks and a column scan
  // for queries, clears by dropping the valid bits
  fog_back #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_is_new (out_is_new)
  );

endmodule

// ===== src/fog_checker.sv =====
`include "feature_occupancy_grid_defines.svh"

module fog_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_opcode,
  input logic       cfg_we,
  input logic       out_valid
);
  import fog_pkg::*;

  // reset leaves no result pending and a cell size update under way
  `FOG_ASSERT_RST(a_reset_state, !rst_n |=> !out_valid && busy, "bad state after reset")

  // at most one query is in the back at a time, so strobes never touch
  `FOG_ASSERT(a_strobe_gap, out_valid |=> !out_valid, "result strobes back to back")

  // a real command occupies the front in the following cycle
  `FOG_ASSERT(a_take_busy, start && !busy && in_opcode != OP_NONE |=> busy,
    "command transfer left the block idle")

  // a register write triggers a cell size update
  `FOG_ASSERT(a_cfg_busy, cfg_we |=> busy, "register write without size update")

endmodule

bind feature_occupancy_grid fog_checker u_fog_checker (.*);
